/* hdl/tcs_pkg.sv */
// ============================================================================
// tcs_pkg
// Shared types and character codes for the Tcl-style command splitter.
// ============================================================================
`timescale 1ns / 1ps

package tcs_pkg;

    // Default nesting limit for the brace and bracket counters.
    localparam int unsigned NEST_LIMIT_DEF = 255;

    // Character codes that steer the lexer.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // One character of script text.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    // One marked character.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       keep;
        logic       command_end;
        logic       depth_saturated;
    } t_out_item;

endpackage

/* hdl/tcl_command_splitter_top.sv */
// ============================================================================
// tcl_command_splitter_top
// Marks Tcl-style command boundaries in a stream of script characters.
// ============================================================================
`timescale 1ns / 1ps

// The splitter takes one character per clock while the sink does not stall
// and returns it with a keep mark and a command-end mark, one result per
// character, in order. A character is registered on arrival; then the lexer
// state (escape, quote and comment flags, command-start flag, and the brace
// and bracket depth counters) is read and updated by a single level of
// decode logic, and the marked character is written to the output register.
// Throughput is one character per clock as long as the sink does not stall;
// the lexer state update for one character done in combinational logic is what
// sets that figure. When the sink stalls, one character can still be taken
// into the input register before the stall reaches the source. Depth
// counters stop at NEST_LIMIT and flag the character that tried to go past
// it. A character with last_byte set ends the current command and returns
// the lexer to its reset state. Whitespace trimming and empty command
// removal are left to the logic downstream.
module tcl_command_splitter_top #(
    parameter int unsigned NEST_LIMIT = tcs_pkg::NEST_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcs_pkg::t_out_item o_out_data
);
    import tcs_pkg::*;

    // Counter width follows the limit so that the limit itself fits.
    localparam int unsigned LVL_W = $clog2(NEST_LIMIT + 1);
    localparam logic [LVL_W-1:0] LIMIT_V = LVL_W'(NEST_LIMIT);
    localparam logic [LVL_W-1:0] LVL_ZERO = '0;
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

    // Input register stage.
    logic     r_in_valid;
    t_in_item r_in_data;

    // Output register stage.
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;

    // Lexer state and its next value.
    logic             r_esc,     n_esc;
    logic             r_quote,   n_quote;
    logic             r_comment, n_comment;
    logic             r_start,   n_start;
    logic [LVL_W-1:0] r_brace,   n_brace;
    logic [LVL_W-1:0] r_brack,   n_brack;

    logic out_load;
    logic in_load;
    logic step;

    // The output register takes a new result whenever it is empty or its
    // current result is being transferred out in this cycle.
    assign out_load = !r_out_valid || !i_out_stall;
    // The input register refills whenever its character moves on.
    assign in_load  = !r_in_valid || out_load;
    // The lexer advances exactly once for each character that moves on.
    assign step     = r_in_valid && out_load;

    assign o_in_stall  = !in_load;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Next-state and result decode for the character in the input register.
    always_comb begin
        logic [7:0] c;
        logic       blank;
        logic       keep;
        logic       cmd_end;
        logic       sat;

        c     = r_in_data.text_byte;
        blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        keep    = 1'b1;
        cmd_end = 1'b0;
        sat     = 1'b0;

        n_esc     = r_esc;
        n_quote   = r_quote;
        n_comment = r_comment;
        n_start   = r_start;
        n_brace   = r_brace;
        n_brack   = r_brack;

        if (r_comment) begin
            // Everything in a comment is dropped; its newline ends the command.
            keep = 1'b0;
            if (c == CH_NL) begin
                n_comment = 1'b0;
                cmd_end   = 1'b1;
                n_start   = 1'b1;
            end
        end else if (r_esc) begin
            n_esc   = 1'b0;
            n_start = 1'b0;
        end else if (c == CH_BSLASH) begin
            n_esc = 1'b1;
        end else if (!r_quote && (r_brace == LVL_ZERO) && (r_brack == LVL_ZERO)
                     && (c == CH_HASH) && r_start) begin
            n_comment = 1'b1;
            keep      = 1'b0;
        end else if ((c == CH_DQUOTE) && (r_brace == LVL_ZERO)) begin
            n_quote = !r_quote;
            n_start = 1'b0;
        end else begin
            if (!r_quote) begin
                case (c)
                    CH_LBRACE: begin
                        if (r_brace >= LIMIT_V) begin
                            sat = 1'b1;
                        end else begin
                            n_brace = r_brace + LVL_ONE;
                        end
                    end
                    CH_RBRACE: begin
                        if (r_brace != LVL_ZERO) begin
                            n_brace = r_brace - LVL_ONE;
                        end
                    end
                    CH_LBRACK: begin
                        if (r_brack >= LIMIT_V) begin
                            sat = 1'b1;
                        end else begin
                            n_brack = r_brack + LVL_ONE;
                        end
                    end
                    CH_RBRACK: begin
                        if (r_brack != LVL_ZERO) begin
                            n_brack = r_brack - LVL_ONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // A separator counts only at top level, after this character's
            // own depth update.
            if (!r_quote && (n_brace == LVL_ZERO) && (n_brack == LVL_ZERO)
                && ((c == CH_NL) || (c == CH_SEMI))) begin
                keep    = 1'b0;
                cmd_end = 1'b1;
                n_start = 1'b1;
            end else begin
                n_start = r_start && blank;
            end
        end

        // The final character of a text closes the command and starts over.
        if (r_in_data.last_byte) begin
            cmd_end   = 1'b1;
            n_esc     = 1'b0;
            n_quote   = 1'b0;
            n_comment = 1'b0;
            n_start   = 1'b1;
            n_brace   = LVL_ZERO;
            n_brack   = LVL_ZERO;
        end

        n_out_data.byte_out        = c;
        n_out_data.keep            = keep;
        n_out_data.command_end     = cmd_end;
        n_out_data.depth_saturated = sat;
    end

    // Control state and lexer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_esc       <= 1'b0;
            r_quote     <= 1'b0;
            r_comment   <= 1'b0;
            r_start     <= 1'b1;
            r_brace     <= LVL_ZERO;
            r_brack     <= LVL_ZERO;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_esc     <= n_esc;
                r_quote   <= n_quote;
                r_comment <= n_comment;
                r_start   <= n_start;
                r_brace   <= n_brace;
                r_brack   <= n_brack;
            end
        end
    end

    // Payload registers hold while their stage is stalled.
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_data <= i_in_data;
        end
        if (step) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

/* hdl/tcs_checker.sv */
// ============================================================================
// tcs_checker
// Port-level checks for the Tcl-style command splitter.
// ============================================================================
`timescale 1ns / 1ps

module tcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input tcs_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tcs_pkg::t_out_item o_out_data
);
    import tcs_pkg::*;

    // A character that is held back stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input changed or was withdrawn");

    // A result that is held by the sink stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or was withdrawn");

    // The source is held back only when a finished result is itself held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Saturation comes only from an opener, and that opener is kept.
    a_sat_opener: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.depth_saturated |->
            o_out_data.keep &&
            ((o_out_data.byte_out == CH_LBRACE) || (o_out_data.byte_out == CH_LBRACK)))
        else $error("saturation flagged on a non-opener or dropped byte");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind tcl_command_splitter_top tcs_checker u_tcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* tb/tcl_command_splitter_top_tb.sv */
// ============================================================================
// tcl_command_splitter_top_tb
// Self-checking bench for the Tcl-style command splitter. Script text is fed
// one character per transfer while both sides idle and stall at random. Every
// accepted character is run through a cycle-free lexer model that predicts
// its keep, command-end and depth-saturated marks. Every result transfer is
// checked in order against that prediction.
// ============================================================================
`timescale 1ns / 1ps

module tcl_command_splitter_top_tb;

    import tcs_pkg::*;

    // The bench runs the block at its default nesting limit.
    localparam int unsigned NEST_LIM = NEST_LIMIT_DEF;

    // Cycles without any transfer on either side before the run is abandoned.
    // Random stalls never come close to this, even at the heaviest idling.
    localparam int unsigned STALL_LIMIT = 2000;

    // Extra cycles after the last expected mark, so that a stray result
    // coming out of the two-stage pipeline is still caught.
    localparam int unsigned DRAIN_CYCLES = 8;

    // Mismatches beyond this count are only counted, not printed.
    localparam int unsigned REPORT_MAX = 10;

    // Rough number of random script characters per idling phase.
    localparam int unsigned PHASE_CHARS = 72;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;

    tcl_command_splitter_top #(
        .NEST_LIMIT (NEST_LIM)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------------
    // Scoreboard. It carries its own copy of the lexer state. Every accepted
    // character advances that state and queues the marks that the block must
    // return for it. Every result transfer is checked against the oldest
    // entry in that queue.
    // ------------------------------------------------------------------------
    class command_mark_scoreboard;
        bit          escaped;
        bit          quoted;
        bit          in_comment;
        bit          cmd_start;
        int unsigned brace_lvl;
        int unsigned bracket_lvl;
        t_out_item   marks_q[$];
        int unsigned failures;

        function new();
            failures = 0;
            clear_lexer();
        endfunction

        function void clear_lexer();
            escaped     = 1'b0;
            quoted      = 1'b0;
            in_comment  = 1'b0;
            cmd_start   = 1'b1;
            brace_lvl   = 0;
            bracket_lvl = 0;
        endfunction

        function int unsigned pending();
            return marks_q.size();
        endfunction

        // Predicts the marks for one accepted character.
        function void note_input(t_in_item it);
            logic [7:0] c;
            bit         keep;
            bit         fin;
            bit         sat;
            t_out_item  mark;
            c    = it.text_byte;
            keep = 1'b1;
            fin  = 1'b0;
            sat  = 1'b0;
            if (in_comment) begin
                // A comment swallows everything, backslashes included, up to
                // the newline that closes the command.
                keep = 1'b0;
                if (c == CH_NL) begin
                    in_comment = 1'b0;
                    fin        = 1'b1;
                    cmd_start  = 1'b1;
                end
            end else if (escaped) begin
                escaped   = 1'b0;
                cmd_start = 1'b0;
            end else if (c == CH_BSLASH) begin
                escaped = 1'b1;
            end else if (!quoted && brace_lvl == 0 && bracket_lvl == 0 &&
                         c == CH_HASH && cmd_start) begin
                in_comment = 1'b1;
                keep       = 1'b0;
            end else if (c == CH_DQUOTE && brace_lvl == 0) begin
                quoted    = !quoted;
                cmd_start = 1'b0;
            end else begin
                if (!quoted) begin
                    case (c)
                        CH_LBRACE: begin
                            if (brace_lvl >= NEST_LIM) sat = 1'b1;
                            else brace_lvl++;
                        end
                        CH_RBRACE: begin
                            if (brace_lvl > 0) brace_lvl--;
                        end
                        CH_LBRACK: begin
                            if (bracket_lvl >= NEST_LIM) sat = 1'b1;
                            else bracket_lvl++;
                        end
                        CH_RBRACK: begin
                            if (bracket_lvl > 0) bracket_lvl--;
                        end
                        default: ;
                    endcase
                end
                if (!quoted && brace_lvl == 0 && bracket_lvl == 0 &&
                    (c == CH_NL || c == CH_SEMI)) begin
                    keep      = 1'b0;
                    fin       = 1'b1;
                    cmd_start = 1'b1;
                end else begin
                    cmd_start = cmd_start &&
                                (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
                end
            end
            // The final character of a text always closes the command and
            // leaves the lexer as it was after reset.
            if (it.last_byte) begin
                fin = 1'b1;
                clear_lexer();
            end
            mark.byte_out        = c;
            mark.keep            = keep;
            mark.command_end     = fin;
            mark.depth_saturated = sat;
            marks_q = {marks_q, mark};
        endfunction

        // Compares one result transfer with the oldest predicted marks.
        function void check_result(t_out_item got);
            t_out_item want;
            if (marks_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: byte=%h keep=%b end=%b sat=%b",
                             got.byte_out, got.keep, got.command_end,
                             got.depth_saturated);
                return;
            end
            want = marks_q.pop_front();
            if (got.byte_out !== want.byte_out || got.keep !== want.keep ||
                got.command_end !== want.command_end ||
                got.depth_saturated !== want.depth_saturated) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mark mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                             want.byte_out, want.keep, want.command_end,
                             want.depth_saturated, got.byte_out, got.keep,
                             got.command_end, got.depth_saturated);
            end
        endfunction
    endclass

    command_mark_scoreboard sb;

    // Characters waiting to be sent, and the idling rates of the current phase.
    t_in_item    script_q[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned quiet_cycles;

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The sink stalls at random, at whatever rate the current phase sets.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Both sides are watched at the rising edge, with the values that were
    // settled before it. A character always passes the input and output registers
    // before it leaves the block, so noting the input ahead of the check is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_input(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        end
    end

    // Watchdog: a long stretch without any transfer means the block hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void put_char(input logic [7:0] c, input logic last);
        t_in_item it;
        it.text_byte = c;
        it.last_byte = last;
        script_q = {script_q, it};
    endfunction

    function automatic void put_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], last_at_end && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] letter();
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Drives one nesting counter past its limit, so that several openers in
    // a row are flagged. A few closers follow, and then the text is ended
    // to bring the lexer back to its start state.
    function automatic void deep_nest(input logic [7:0] opener,
                                      input logic [7:0] closer);
        repeat (NEST_LIM + 3) put_char(opener, 1'b0);
        repeat ($urandom_range(1, 4)) put_char(closer, 1'b0);
        put_char(letter(), 1'b1);
    endfunction

    // Queues random script texts until about the given number of characters
    // is reached. Most of them are well-formed commands with random words:
    // plain, braced, bracketed, quoted and escaped. Comment lines and
    // unmatched closers are mixed in, along with bursts of arbitrary bytes
    // that may end a text at any point. Every text ends with a final
    // character, so a broken stretch never spills far into the next one.
    function automatic void fill_phase(input int unsigned chars);
        int unsigned start;
        int unsigned n_cmds;
        int unsigned n_words;
        int unsigned depth;
        logic [7:0]  c;
        start = script_q.size();
        while (script_q.size() - start < chars) begin
            n_cmds = $urandom_range(1, 6);
            for (int k = 0; k < n_cmds; k++) begin
                if ($urandom_range(0, 5) == 0) begin
                    // A comment line, sometimes behind leading blanks.
                    if ($urandom_range(0, 1)) put_char(CH_SPACE, 1'b0);
                    put_char(CH_HASH, 1'b0);
                    repeat ($urandom_range(0, 6)) begin
                        c = 8'($urandom_range(0, 255));
                        if (c == CH_NL || $urandom_range(0, 4) == 0) c = CH_BSLASH;
                        put_char(c, 1'b0);
                    end
                    put_char(CH_NL, 1'b0);
                    continue;
                end
                n_words = $urandom_range(1, 4);
                for (int w = 0; w < n_words; w++) begin
                    if (w > 0) put_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
                    case ($urandom_range(0, 6))
                        0, 1: begin
                            repeat ($urandom_range(1, 5)) put_char(letter(), 1'b0);
                        end
                        2: begin
                            // Braced word: separators and quotes inside it
                            // are plain text.
                            depth = $urandom_range(1, 3);
                            repeat (depth) put_char(CH_LBRACE, 1'b0);
                            repeat ($urandom_range(0, 5)) begin
                                case ($urandom_range(0, 5))
                                    0: put_char(CH_SEMI, 1'b0);
                                    1: put_char(CH_NL, 1'b0);
                                    2: put_char(CH_DQUOTE, 1'b0);
                                    3: put_char(CH_HASH, 1'b0);
                                    default: put_char(letter(), 1'b0);
                                endcase
                            end
                            repeat (depth) put_char(CH_RBRACE, 1'b0);
                        end
                        3: begin
                            put_char(CH_LBRACK, 1'b0);
                            repeat ($urandom_range(1, 4)) put_char(letter(), 1'b0);
                            if ($urandom_range(0, 1)) begin
                                put_char(CH_SPACE, 1'b0);
                                put_char(CH_LBRACE, 1'b0);
                                put_char(CH_SEMI, 1'b0);
                                put_char(CH_RBRACE, 1'b0);
                            end
                            put_char(CH_RBRACK, 1'b0);
                        end
                        4: begin
                            // Quoted word: nesting characters are not counted
                            // here, and an escaped quote does not close it.
                            put_char(CH_DQUOTE, 1'b0);
                            repeat ($urandom_range(0, 5)) begin
                                case ($urandom_range(0, 6))
                                    0: put_char(CH_SEMI, 1'b0);
                                    1: put_char(CH_NL, 1'b0);
                                    2: put_char(CH_LBRACE, 1'b0);
                                    3: put_char(CH_RBRACK, 1'b0);
                                    4: begin
                                        put_char(CH_BSLASH, 1'b0);
                                        put_char(CH_DQUOTE, 1'b0);
                                    end
                                    default: put_char(letter(), 1'b0);
                                endcase
                            end
                            put_char(CH_DQUOTE, 1'b0);
                        end
                        5: begin
                            put_char(CH_BSLASH, 1'b0);
                            put_char(8'($urandom_range(0, 255)), 1'b0);
                        end
                        default: begin
                            case ($urandom_range(0, 2))
                                0: put_char(CH_RBRACE, 1'b0);
                                1: put_char(CH_RBRACK, 1'b0);
                                default: put_char(8'($urandom_range(0, 255)), 1'b0);
                            endcase
                        end
                    endcase
                end
                case ($urandom_range(0, 2))
                    0: put_char(CH_SEMI, 1'b0);
                    1: put_char(CH_NL, 1'b0);
                    default: begin
                        put_char(CH_CR, 1'b0);
                        put_char(CH_NL, 1'b0);
                    end
                endcase
            end
            if ($urandom_range(0, 4) == 0) begin
                // Noise: arbitrary bytes, any of which may end the text.
                repeat ($urandom_range(1, 8))
                    put_char(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            end
            put_char(8'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    // Sends every queued character with random source gaps. Valid stays high
    // from one transfer into the next when no gap is drawn. The payload is
    // only changed once the current character has been taken.
    task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
        t_in_item it;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        while (script_q.size() != 0) begin
            it = script_q.pop_front();
            while ($urandom_range(0, 99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= it;
            do @(posedge i_clk); while (o_in_stall);
        end
    endtask

    initial begin
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles  = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts. The first covers the byte extremes, and its final
        // character resets the lexer. The second is a comment behind a blank,
        // with a backslash and a semicolon inside that have no effect, closed
        // by a newline. The third holds an escaped semicolon that is kept,
        // then a real separator. The fourth has unmatched closers, a quote
        // that does not toggle inside braces, and a separator once the depth
        // is back at zero. The last has a brace and a semicolon inside quotes
        // that count for nothing, and it ends on a final character.
        put_char(8'h00, 1'b0);
        put_char(8'hFF, 1'b1);
        put_text(" #c\\;x\n", 1'b0);
        put_text("a\\;b;", 1'b0);
        put_text("}]{\"};", 1'b0);
        put_text("\"{;\"x", 1'b1);

        // Phase one: the sink stalls more often than the source idles. Brace nesting
        // is pushed past its limit here.
        fill_phase(PHASE_CHARS);
        deep_nest(CH_LBRACE, CH_RBRACE);
        run_phase(36, 62);

        // Phase two: the source idles more often than the sink stalls.
        fill_phase(PHASE_CHARS);
        run_phase(62, 36);

        // Phase three: full rate on both sides.
        fill_phase(PHASE_CHARS);
        run_phase(0, 0);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
